### rtl/pan_tilt_servo_command_filter_core_macros.svh
// Assertion macros used by the checker file.
`ifndef PAN_TILT_SERVO_COMMAND_FILTER_CORE_MACROS_SVH
`define PAN_TILT_SERVO_COMMAND_FILTER_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define PTSCF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PTSCF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/ptscf_pkg.sv
package ptscf_pkg;

   // Filter and pulse constants
   localparam logic [15:0]        FILT_RESET      = 16'd23040;  // 90.0 in Q8.8
   localparam logic [8:0]         ALPHA_ONE       = 9'd256;
   localparam logic [7:0]         ANGLE_MAX       = 8'd180;
   localparam logic signed [16:0] ANGLE_OFFSET    = 17'sd9000;
   localparam logic signed [16:0] ANGLE_CLAMP_SUM = 17'sd18100; // sum giving 181 degrees
   localparam logic [7:0]         ANGLE_DIVISOR   = 8'd100;
   localparam logic [8:0]         PULSE_DIVISOR   = 9'd180;

   // Configuration reset values
   localparam logic [8:0]  BLEND_WEIGHT_RESET = 9'd256;
   localparam logic [7:0]  DEADBAND_RESET     = 8'd0;
   localparam logic [11:0] PULSE_MIN_RESET    = 12'd150;
   localparam logic [11:0] PULSE_MAX_RESET    = 12'd600;

   // Configuration address map
   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_BLEND_WEIGHT = 2'd0;
   localparam logic [1:0] REG_DEADBAND     = 2'd1;
   localparam logic [1:0] REG_PULSE_MIN    = 2'd2;
   localparam logic [1:0] REG_PULSE_MAX    = 2'd3;

   // Serial step counts per phase
   localparam int ANGLE_STEPS  = 8;   // quotient bits of the angle divide
   localparam int FILTER_STEPS = 9;   // weight bits
   localparam int MUL_STEPS    = 8;   // angle bits of the span multiply
   localparam int PULSE_STEPS  = 12;  // quotient bits of the pulse divide
   localparam int CNT_W        = $clog2(PULSE_STEPS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ANGLE,
      ST_FILTER,
      ST_MUL,
      ST_PULSE,
      ST_HOLD
   } phase_type;

   // Sequencer to axis lane control
   typedef struct packed {
      phase_type phase;
      logic      load;
      logic      last;
      logic      alpha_bit;
      logic      beta_bit;
   } ctrl_type;

   typedef struct packed {
      logic signed [15:0] yaw_centideg;
      logic signed [15:0] pitch_centideg;
   } req_type;

   typedef struct packed {
      logic [11:0] pan_pulse;
      logic        pan_update;
      logic [11:0] tilt_pulse;
      logic        tilt_update;
   } rsp_type;

endpackage

### rtl/ptscf_axis.sv
module ptscf_axis (
   input  logic               clock,
   input  logic               reset,
   input  ptscf_pkg::ctrl_type ctrl,
   input  logic signed [15:0] sample,
   input  logic [7:0]         deadband,
   input  logic [11:0]        pulse_from,
   input  logic [11:0]        pulse_to,
   output logic [11:0]        pulse,
   output logic               update
);
   import ptscf_pkg::*;

   logic [15:0] filt_ff, filt_in;
   logic [7:0]  q_ff, q_in;
   logic [7:0]  rem_ff, rem_in;
   logic [23:0] acc_ff, acc_in;
   logic        lo_ff, lo_in;
   logic        hi_ff, hi_in;
   logic        upd_ff, upd_in;

   logic signed [16:0] sum;
   logic               sum_high;
   logic [7:0]         angle;
   logic [7:0]         cur;
   logic [7:0]         diff;
   logic               upd_now;
   logic [23:0]        fsum;
   logic signed [12:0] span;
   logic               span_neg;
   logic [12:0]        span_abs;
   logic [11:0]        mag;
   logic [23:0]        msum;
   logic [7:0]         a_trial;
   logic               a_ge;
   logic [7:0]         a_rem;
   logic [8:0]         p_trial;
   logic               p_ge;
   logic [8:0]         p_rem;

   // Offset the sample and flag the clamp cases
   assign sum      = {sample[15], sample} + ANGLE_OFFSET;
   assign sum_high = !sum[16] && (sum >= ANGLE_CLAMP_SUM);

   // Clamped integer angle once the divide is done
   assign angle = hi_ff ? ANGLE_MAX : (lo_ff ? 8'd0 : q_ff);

   // Deadband test against the integer part of the filter
   assign cur     = filt_ff[15:8];
   assign diff    = (angle >= cur) ? (angle - cur) : (cur - angle);
   assign upd_now = diff > deadband;

   // Weighted sum, MSB first over the weight bits
   assign fsum = {acc_ff[22:0], 1'b0}
               + (ctrl.alpha_bit ? {8'h00, angle, 8'h00} : 24'h0)
               + (ctrl.beta_bit  ? {8'h00, filt_ff}      : 24'h0);

   // Span magnitude and sign for the pulse map
   assign span     = $signed({1'b0, pulse_to}) - $signed({1'b0, pulse_from});
   assign span_neg = span[12];
   assign span_abs = span_neg ? (13'd0 - span) : span;
   assign mag      = span_abs[11:0];
   assign msum     = {acc_ff[22:0], 1'b0} + {12'h000, (q_ff[7] ? mag : 12'h000)};

   // Restoring divide steps
   assign a_trial = {rem_ff[6:0], q_ff[7]};
   assign a_ge    = a_trial >= ANGLE_DIVISOR;
   assign a_rem   = a_ge ? (a_trial - ANGLE_DIVISOR) : a_trial;

   assign p_trial = {rem_ff, acc_ff[11]};
   assign p_ge    = p_trial >= PULSE_DIVISOR;
   assign p_rem   = p_ge ? (p_trial - PULSE_DIVISOR) : p_trial;

   // Next-state of the lane datapath
   always_comb begin
      filt_in = filt_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      acc_in  = acc_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      upd_in  = upd_ff;
      if (ctrl.load) begin
         lo_in  = sum[16];
         hi_in  = sum_high;
         rem_in = {1'b0, sum[14:8]};
         q_in   = sum[7:0];
         acc_in = '0;
      end else begin
         case (ctrl.phase)
            ST_ANGLE: begin
               rem_in = {1'b0, a_rem[6:0]};
               q_in   = {q_ff[6:0], a_ge};
            end
            ST_FILTER: begin
               acc_in = fsum;
               if (ctrl.last) begin
                  upd_in = upd_now;
                  acc_in = '0;
                  if (upd_now) begin
                     filt_in = fsum[23:8];
                     q_in    = fsum[23:16];
                  end else begin
                     q_in = filt_ff[15:8];
                  end
               end
            end
            ST_MUL: begin
               acc_in = msum;
               q_in   = {q_ff[6:0], 1'b0};
               if (ctrl.last) begin
                  rem_in = msum[19:12];
                  acc_in = {12'h000, msum[11:0]};
               end
            end
            ST_PULSE: begin
               rem_in = p_rem[7:0];
               acc_in = {acc_ff[23:12], acc_ff[10:0], p_ge};
            end
            default: begin
            end
         endcase
      end
   end

   // Filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         filt_ff <= FILT_RESET;
      end else begin
         filt_ff <= filt_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      acc_ff <= acc_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      upd_ff <= upd_in;
   end

   // Quotient holds |a*span|/180 after the pulse divide
   assign pulse  = span_neg ? (pulse_from - acc_ff[11:0]) : (pulse_from + acc_ff[11:0]);
   assign update = upd_ff;

endmodule

### rtl/pan_tilt_servo_command_filter_core.sv
// Pan/tilt servo command filter. Each accepted beat carries yaw and pitch in
// hundredths of a degree; each becomes a clamped 0..180 degree angle, passes a
// deadband and a Q8 exponential average (per-axis Q8.8 state, reset 90.0), and
// the integer filtered angle maps onto pulse_min..pulse_max (pan reversed,
// tilt direct). One result beat per input beat. Items are processed one at a
// time through a bit-serial datapath: angle divide, filter multiply, span
// multiply, pulse divide, then a hold state that passes the result to the
// output register; a new beat is taken only once the last has left the hold
// state. The output register lets the next beat start while a result waits.
module pan_tilt_servo_command_filter_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  ptscf_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output ptscf_pkg::rsp_type                   rsp_data,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [ptscf_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);
   import ptscf_pkg::*;

   localparam logic [CNT_W-1:0] ANGLE_LAST  = CNT_W'(ANGLE_STEPS - 1);
   localparam logic [CNT_W-1:0] FILTER_LAST = CNT_W'(FILTER_STEPS - 1);
   localparam logic [CNT_W-1:0] MUL_LAST    = CNT_W'(MUL_STEPS - 1);
   localparam logic [CNT_W-1:0] PULSE_LAST  = CNT_W'(PULSE_STEPS - 1);

   phase_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [8:0]        alpha_sh_ff, alpha_sh_in;
   logic [8:0]        beta_sh_ff, beta_sh_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic [8:0]        blend_weight_ff, blend_weight_in;
   logic [7:0]        deadband_ff, deadband_in;
   logic [11:0]       pulse_min_ff, pulse_min_in;
   logic [11:0]       pulse_max_ff, pulse_max_in;

   logic              req_fire;
   logic              step_last;
   logic              rsp_load;
   logic              csr_write;
   logic [1:0]        csr_index;
   logic [8:0]        alpha_eff;
   ctrl_type          ctrl;
   logic [11:0]       pan_pulse;
   logic              pan_upd;
   logic [11:0]       tilt_pulse;
   logic              tilt_upd;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_load  = (state_ff == ST_HOLD) && (!rsp_valid_ff || rsp_ready);

   // Sequencer: phase and step count
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      step_last = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_ANGLE;
               cnt_in   = '0;
            end
         end
         ST_ANGLE: begin
            step_last = (cnt_ff == ANGLE_LAST);
            cnt_in    = step_last ? '0 : cnt_ff + 1'b1;
            if (step_last) begin
               state_in = ST_FILTER;
            end
         end
         ST_FILTER: begin
            step_last = (cnt_ff == FILTER_LAST);
            cnt_in    = step_last ? '0 : cnt_ff + 1'b1;
            if (step_last) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            step_last = (cnt_ff == MUL_LAST);
            cnt_in    = step_last ? '0 : cnt_ff + 1'b1;
            if (step_last) begin
               state_in = ST_PULSE;
            end
         end
         ST_PULSE: begin
            step_last = (cnt_ff == PULSE_LAST);
            cnt_in    = step_last ? '0 : cnt_ff + 1'b1;
            if (step_last) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Weight shift registers, MSB first during the filter phase
   assign alpha_eff = (blend_weight_ff > ALPHA_ONE) ? ALPHA_ONE : blend_weight_ff;

   always_comb begin
      alpha_sh_in = alpha_sh_ff;
      beta_sh_in  = beta_sh_ff;
      if (req_fire) begin
         alpha_sh_in = alpha_eff;
         beta_sh_in  = ALPHA_ONE - alpha_eff;
      end else if (state_ff == ST_FILTER) begin
         alpha_sh_in = {alpha_sh_ff[7:0], 1'b0};
         beta_sh_in  = {beta_sh_ff[7:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      alpha_sh_ff <= alpha_sh_in;
      beta_sh_ff  <= beta_sh_in;
   end

   // Lane control
   always_comb begin
      ctrl.phase     = state_ff;
      ctrl.load      = req_fire;
      ctrl.last      = step_last;
      ctrl.alpha_bit = alpha_sh_ff[8];
      ctrl.beta_bit  = beta_sh_ff[8];
   end

   // Pan lane: reversed map
   ptscf_axis u_pan (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .sample     (req_data.yaw_centideg),
      .deadband   (deadband_ff),
      .pulse_from (pulse_max_ff),
      .pulse_to   (pulse_min_ff),
      .pulse      (pan_pulse),
      .update     (pan_upd)
   );

   // Tilt lane: direct map
   ptscf_axis u_tilt (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .sample     (req_data.pitch_centideg),
      .deadband   (deadband_ff),
      .pulse_from (pulse_min_ff),
      .pulse_to   (pulse_max_ff),
      .pulse      (tilt_pulse),
      .update     (tilt_upd)
   );

   // Result register
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (rsp_load) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.pan_pulse   = pan_pulse;
         rsp_data_in.pan_update  = pan_upd;
         rsp_data_in.tilt_pulse  = tilt_pulse;
         rsp_data_in.tilt_update = tilt_upd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Configuration registers
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[3:2];
   assign pready    = 1'b1;

   always_comb begin
      blend_weight_in = blend_weight_ff;
      deadband_in     = deadband_ff;
      pulse_min_in    = pulse_min_ff;
      pulse_max_in    = pulse_max_ff;
      if (csr_write) begin
         case (csr_index)
            REG_BLEND_WEIGHT: blend_weight_in = pwdata[8:0];
            REG_DEADBAND:     deadband_in     = pwdata[7:0];
            REG_PULSE_MIN:    pulse_min_in    = pwdata[11:0];
            REG_PULSE_MAX:    pulse_max_in    = pwdata[11:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_weight_ff <= BLEND_WEIGHT_RESET;
         deadband_ff     <= DEADBAND_RESET;
         pulse_min_ff    <= PULSE_MIN_RESET;
         pulse_max_ff    <= PULSE_MAX_RESET;
      end else begin
         blend_weight_ff <= blend_weight_in;
         deadband_ff     <= deadband_in;
         pulse_min_ff    <= pulse_min_in;
         pulse_max_ff    <= pulse_max_in;
      end
   end

   // Register readback
   always_comb begin
      case (csr_index)
         REG_BLEND_WEIGHT: prdata = {23'h0, blend_weight_ff};
         REG_DEADBAND:     prdata = {24'h0, deadband_ff};
         REG_PULSE_MIN:    prdata = {20'h0, pulse_min_ff};
         REG_PULSE_MAX:    prdata = {20'h0, pulse_max_ff};
         default:          prdata = '0;
      endcase
   end

endmodule

### rtl/ptscf_checker.sv
`include "pan_tilt_servo_command_filter_core_macros.svh"

module ptscf_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input ptscf_pkg::rsp_type rsp_data
);
   import ptscf_pkg::*;

   // One item in flight: an accepted beat blocks the input side
   `PTSCF_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "input accepted while an item is in flight")

   // A new result only appears just after the input side was busy
   `PTSCF_ASSERT_NOW(a_result_after_work, clock, reset, $rose(rsp_valid), $past(!req_ready), "result appeared without work behind it")

   // A stalled result beat holds
   `PTSCF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result beat changed")

endmodule

bind pan_tilt_servo_command_filter_core ptscf_checker u_ptscf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### verif/pan_tilt_servo_command_filter_core_test.sv
`timescale 1ns / 1ps

module pan_tilt_servo_command_filter_core_test;
   import ptscf_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_BEATS   = 200;
   localparam int IDLE_PERCENT  = 37;

   // Predicts servo pulses from orientation beats and checks result beats
   class servo_filter_scoreboard;
      logic [8:0]  blend_weight;
      logic [7:0]  deadband_deg;
      logic [11:0] pulse_min;
      logic [11:0] pulse_max;
      logic [15:0] pan_q8;
      logic [15:0] tilt_q8;
      rsp_type     expected_q[$];
      int          errors;

      function new();
         blend_weight = BLEND_WEIGHT_RESET;
         deadband_deg = DEADBAND_RESET;
         pulse_min    = PULSE_MIN_RESET;
         pulse_max    = PULSE_MAX_RESET;
         pan_q8       = FILT_RESET;
         tilt_q8      = FILT_RESET;
         errors       = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_BLEND_WEIGHT: blend_weight = value[8:0];
            REG_DEADBAND:     deadband_deg = value[7:0];
            REG_PULSE_MIN:    pulse_min    = value[11:0];
            REG_PULSE_MAX:    pulse_max    = value[11:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] reg_value(logic [1:0] idx);
         case (idx)
            REG_BLEND_WEIGHT: return {23'd0, blend_weight};
            REG_DEADBAND:     return {24'd0, deadband_deg};
            REG_PULSE_MIN:    return {20'd0, pulse_min};
            REG_PULSE_MAX:    return {20'd0, pulse_max};
            default:          return '0;
         endcase
      endfunction

      // floor((v + 90.00 deg) / 1 deg), clamped to 0..180
      function logic [7:0] angle_of(logic signed [15:0] centideg);
         int sum;
         sum = int'(centideg) + int'(ANGLE_OFFSET);
         if (sum < 0) return '0;
         sum = sum / int'(ANGLE_DIVISOR);
         if (sum > int'(ANGLE_MAX)) return ANGLE_MAX;
         return sum[7:0];
      endfunction

      // Deadband test, then Q8 exponential average; returns the update flag
      function logic smooth_axis(inout logic [15:0] filt, input logic [7:0] angle);
         int whole;
         int gap;
         int weight;
         int acc;
         whole  = int'(filt[15:8]);
         gap    = (int'(angle) > whole) ? int'(angle) - whole : whole - int'(angle);
         weight = (blend_weight > ALPHA_ONE) ? int'(ALPHA_ONE) : int'(blend_weight);
         if (gap <= int'(deadband_deg)) return 1'b0;
         acc  = weight * (int'(angle) << 8) + (int'(ALPHA_ONE) - weight) * int'(filt);
         filt = acc[23:8];
         return 1'b1;
      endfunction

      // Linear map with truncation toward zero
      function logic [11:0] pulse_of(logic [7:0] whole, logic [11:0] start_tick,
                                     logic [11:0] end_tick);
         int span;
         int ticks;
         span  = int'(end_tick) - int'(start_tick);
         ticks = int'(whole) * span / int'(PULSE_DIVISOR) + int'(start_tick);
         return ticks[11:0];
      endfunction

      function void note_item(req_type item);
         rsp_type    want;
         logic [7:0] pan_angle;
         logic [7:0] tilt_angle;
         pan_angle        = angle_of(item.yaw_centideg);
         tilt_angle       = angle_of(item.pitch_centideg);
         want.pan_update  = smooth_axis(pan_q8, pan_angle);
         want.tilt_update = smooth_axis(tilt_q8, tilt_angle);
         // pan runs reversed: from pulse_max toward pulse_min
         want.pan_pulse   = pulse_of(pan_q8[15:8], pulse_max, pulse_min);
         want.tilt_pulse  = pulse_of(tilt_q8[15:8], pulse_min, pulse_max);
         expected_q.push_back(want);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, got %h", $time, got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.pan_pulse !== want.pan_pulse) begin
            $display("%0t: pan_pulse expected %0d, got %0d", $time, want.pan_pulse,
                     got.pan_pulse);
            errors++;
         end
         if (got.pan_update !== want.pan_update) begin
            $display("%0t: pan_update expected %0d, got %0d", $time, want.pan_update,
                     got.pan_update);
            errors++;
         end
         if (got.tilt_pulse !== want.tilt_pulse) begin
            $display("%0t: tilt_pulse expected %0d, got %0d", $time, want.tilt_pulse,
                     got.tilt_pulse);
            errors++;
         end
         if (got.tilt_update !== want.tilt_update) begin
            $display("%0t: tilt_update expected %0d, got %0d", $time, want.tilt_update,
                     got.tilt_update);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]           pwdata = '0;
   logic [31:0]           prdata;
   logic                  pready;

   servo_filter_scoreboard sb = new();
   bit                     steady = 1'b0;
   int                     cycle_count = 0;
   int                     walk_yaw = 0;
   int                     walk_pitch = 0;

   pan_tilt_servo_command_filter_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #5 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("pan_tilt_servo_command_filter_core: mismatch");
         $finish;
      end
   end

   // Result side: random backpressure, check every accepted beat
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_data);
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
   end

   task automatic send_beat(input logic signed [15:0] yaw, input logic signed [15:0] pitch);
      req_type item;
      item.yaw_centideg   = yaw;
      item.pitch_centideg = pitch;
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_item(item);
   endtask

   task automatic wait_drained();
      while (sb.expected_q.size() != 0) @(posedge clock);
   endtask

   // Write one register, then read it back
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      sb.set_reg(idx, value);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== sb.reg_value(idx)) begin
         $display("%0t: register %0d read expected %0d, got %0d", $time, idx,
                  sb.reg_value(idx), prdata);
         sb.errors++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input int alpha, input int deadband, input int pmin,
                             input int pmax);
      // drop the last beat so it is not taken again once the block goes idle
      req_valid <= 1'b0;
      wait_drained();
      write_reg(REG_BLEND_WEIGHT, alpha);
      write_reg(REG_DEADBAND, deadband);
      write_reg(REG_PULSE_MIN, pmin);
      write_reg(REG_PULSE_MAX, pmax);
   endtask

   // Small moves around a wandering pose (the largest share), some jumps, some raw noise
   task automatic random_beat();
      int pick;
      int yaw;
      int pitch;
      pick = $urandom_range(99);
      if (pick < 45) begin
         walk_yaw   += int'($urandom_range(3000)) - 1500;
         walk_pitch += int'($urandom_range(3000)) - 1500;
         if (walk_yaw > 18000) walk_yaw = 18000;
         if (walk_yaw < -18000) walk_yaw = -18000;
         if (walk_pitch > 18000) walk_pitch = 18000;
         if (walk_pitch < -18000) walk_pitch = -18000;
         yaw   = walk_yaw;
         pitch = walk_pitch;
      end else if (pick < 80) begin
         yaw   = int'($urandom_range(36000)) - 18000;
         pitch = int'($urandom_range(36000)) - 18000;
      end else begin
         yaw   = $urandom;
         pitch = $urandom;
      end
      send_beat(yaw[15:0], pitch[15:0]);
   endtask

   initial begin
      int alpha_v;
      int deadband_v;
      int pmin_v;
      int pmax_v;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: centered pose, field extremes, clamp and floor edges
      send_beat(16'sd0, 16'sd0);
      send_beat(16'sh8000, 16'sh7FFF);
      send_beat(-16'sd18000, 16'sd18000);
      send_beat(-16'sd9001, 16'sd9099);
      send_beat(-16'sd9000, 16'sd9100);
      send_beat(-16'sd8901, -16'sd8999);
      send_beat(-16'sd8900, 16'sd8999);
      send_beat(16'sh7FFF, 16'sh8000);

      // Deadband edge: pan moves by exactly the band, tilt by one more
      set_config(256, 10, 150, 600);
      send_beat(16'sd0, 16'sd0);
      send_beat(16'sd1000, 16'sd1100);

      // Half weight smoothing, then zero weight (flag set, filter stays)
      set_config(128, 0, 150, 600);
      send_beat(-16'sd9000, 16'sd18000);
      send_beat(16'sd5000, -16'sd5000);
      set_config(0, 0, 4095, 0);
      send_beat(16'sd3000, -16'sd3000);

      // Weight above one, full pulse range
      set_config(511, 0, 0, 4095);
      send_beat(16'sd2000, -16'sd2000);
      send_beat(-16'sd18000, 16'sd18000);

      // Wide deadbands hold everything; equal limits
      set_config(300, 255, 77, 77);
      send_beat(-16'sd18000, 16'sd18000);
      set_config(257, 180, 4095, 4095);
      send_beat(16'sd18000, -16'sd18000);

      // Smallest weight creeps
      set_config(1, 0, 0, 0);
      send_beat(16'sd18000, -16'sd18000);
      send_beat(16'sd0, 16'sd0);

      // Random phases, each with its own settings
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0:       alpha_v = 256;
            1:       alpha_v = 0;
            2:       alpha_v = 511;
            3:       alpha_v = 1;
            4:       alpha_v = 255;
            5:       alpha_v = 257;
            default: alpha_v = $urandom_range(256);
         endcase
         case (p)
            3:       deadband_v = 255;
            6:       deadband_v = 180;
            default: deadband_v = $urandom_range(15);
         endcase
         case (p)
            1: begin
               pmin_v = 0;
               pmax_v = 4095;
            end
            2: begin
               pmin_v = 4095;
               pmax_v = 0;
            end
            4: begin
               pmin_v = $urandom_range(4095);
               pmax_v = pmin_v;
            end
            default: begin
               pmin_v = $urandom_range(4095);
               pmax_v = $urandom_range(4095);
            end
         endcase
         set_config(alpha_v, deadband_v, pmin_v, pmax_v);
         steady = (p == 7);
         for (int n = 0; n < PHASE_BEATS; n++) random_beat();
      end
      req_valid <= 1'b0;

      wait_drained();
      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("pan_tilt_servo_command_filter_core: match");
      end else begin
         $display("pan_tilt_servo_command_filter_core: mismatch");
      end
      $finish;
   end

endmodule
